// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the row buffer timing RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/drbt_pkg.sv =====
// Types and constants for the DRAM row buffer timing block.
// No dependencies; imported by drbt_sched, dram_row_buffer_timing and the testbench.
`default_nettype none

package drbt_pkg;

   // Field widths
   localparam int DELAY_W = 10;
   localparam int ROW_W   = 10;
   localparam int COL_W   = 10;
   localparam int ADDR_W  = 20;
   localparam int DATA_W  = 32;
   localparam int REG_W   = 5;
   localparam int CORE_W  = 3;
   localparam int CSR_IDX_W = 1;

   // Fixed geometry
   localparam int ROW_BYTES = 1024;
   localparam int NUM_CORES = 8;
   localparam int REG_COUNT = 32;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_DELAY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_DELAY = 1'd1;
   localparam logic [DELAY_W-1:0]   ROW_DELAY_RESET = 10'd10;
   localparam logic [DELAY_W-1:0]   COL_DELAY_RESET = 10'd2;

   // Work done in a cycle
   localparam logic [1:0] PH_FREE     = 2'd0;
   localparam logic [1:0] PH_WRITEBACK = 2'd1;
   localparam logic [1:0] PH_ACTIVATE = 2'd2;
   localparam logic [1:0] PH_COLUMN   = 2'd3;

   // Result of one step, load data excluded
   typedef struct packed {
      logic               accepted;
      logic [1:0]         phase;
      logic [ROW_W-1:0]   open_row;
      logic [COL_W-1:0]   column;
      logic               done_res;
      logic               done_is_load;
      logic [REG_W-1:0]   done_reg;
      logic [CORE_W-1:0]  done_core;
      logic               same_core_row_miss;
   } rsp_type;

   // Word store access requested by one step
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [DATA_W-1:0] wdata;
   } mem_op_type;

endpackage

`default_nettype wire

// ===== rtl/core/drbt_sched.sv =====
// Row buffer timing state and per-clock step logic of the DRAM model.
// Depends on drbt_pkg; drives the word store access of the top level.
`default_nettype none

module drbt_sched #(
   parameter int MEM_WORDS = 262144,
   localparam int IDX_W = $clog2(MEM_WORDS)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [drbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [drbt_pkg::DELAY_W-1:0]      csr_write_data,
   input  wire logic                              take,
   input  wire logic                              req_opcode,
   input  wire logic                              req_is_load,
   input  wire logic [drbt_pkg::ADDR_W-1:0]       req_address,
   input  wire logic [drbt_pkg::DATA_W-1:0]       req_store_value,
   input  wire logic [drbt_pkg::REG_W-1:0]        req_dest_reg,
   input  wire logic [drbt_pkg::CORE_W-1:0]       req_core_id,
   output drbt_pkg::rsp_type                      step_rsp,
   output drbt_pkg::mem_op_type                   mem_op,
   output logic [IDX_W-1:0]                       mem_index
);
   import drbt_pkg::*;

   localparam int REM_W = 28;

   // Reduce the word index into the store by restoring subtraction
   function automatic logic [IDX_W-1:0] word_index(input logic [ADDR_W-1:0] addr);
      logic [REM_W-1:0] rem;
      rem = REM_W'(addr >> 2);
      for (int k = 7; k >= 0; k--) begin
         if (rem >= (REM_W'(MEM_WORDS) << k)) begin
            rem = rem - (REM_W'(MEM_WORDS) << k);
         end
      end
      return IDX_W'(rem);
   endfunction

   // Configuration
   logic [DELAY_W-1:0] row_delay_ff;
   logic [DELAY_W-1:0] col_delay_ff;

   // Control state
   logic               busy_ff, busy_in;
   logic               row_valid_ff, row_valid_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [DELAY_W-1:0] wb_left_ff, wb_left_in;
   logic [DELAY_W-1:0] act_left_ff, act_left_in;
   logic [DELAY_W-1:0] col_left_ff, col_left_in;
   logic               prev_valid_ff, prev_valid_in;

   // Active request payload
   logic               act_is_load_ff, act_is_load_in;
   logic [ROW_W-1:0]   act_row_ff, act_row_in;
   logic [COL_W-1:0]   act_col_ff, act_col_in;
   logic [IDX_W-1:0]   act_idx_ff, act_idx_in;
   logic [DATA_W-1:0]  act_value_ff, act_value_in;
   logic [REG_W-1:0]   act_reg_ff, act_reg_in;
   logic [CORE_W-1:0]  act_core_ff, act_core_in;

   // Decode the presented request
   logic               take_req;
   logic [ROW_W-1:0]   row_new;
   logic [COL_W-1:0]   col_new;
   logic [CORE_W-1:0]  core_new;
   logic [REG_W-1:0]   reg_new;
   logic               same_core;
   logic               row_conflict;
   logic [DELAY_W-1:0] wb_start;
   logic [DELAY_W-1:0] act_start;
   logic [DELAY_W-1:0] col_start;

   assign take_req     = take && req_opcode && !busy_ff;
   assign row_new      = ROW_W'(req_address / ROW_BYTES);
   assign col_new      = COL_W'(req_address % ROW_BYTES);
   assign core_new     = CORE_W'(req_core_id % NUM_CORES);
   assign reg_new      = REG_W'(req_dest_reg % REG_COUNT);
   assign same_core    = prev_valid_ff && (act_core_ff == core_new);
   assign row_conflict = row_valid_ff && (row_new != row_ff);
   assign wb_start     = row_conflict ? row_delay_ff : '0;
   assign act_start    = (row_conflict || !row_valid_ff) ? row_delay_ff : '0;
   assign col_start    = (col_delay_ff == '0) ? DELAY_W'(1) : col_delay_ff;

   // Advance the model by one DRAM clock per transfer
   always_comb begin
      busy_in        = busy_ff;
      row_valid_in   = row_valid_ff;
      row_in         = row_ff;
      wb_left_in     = wb_left_ff;
      act_left_in    = act_left_ff;
      col_left_in    = col_left_ff;
      prev_valid_in  = prev_valid_ff;
      act_is_load_in = act_is_load_ff;
      act_row_in     = act_row_ff;
      act_col_in     = act_col_ff;
      act_idx_in     = act_idx_ff;
      act_value_in   = act_value_ff;
      act_reg_in     = act_reg_ff;
      act_core_in    = act_core_ff;
      step_rsp       = '0;
      step_rsp.phase = PH_FREE;
      mem_op         = '0;

      if (take) begin
         // Take a new request while idle
         if (take_req) begin
            act_is_load_in = req_is_load;
            act_row_in     = row_new;
            act_col_in     = col_new;
            act_idx_in     = word_index(req_address);
            act_value_in   = req_store_value;
            act_reg_in     = reg_new;
            act_core_in    = core_new;
            prev_valid_in  = 1'b1;
            wb_left_in     = wb_start;
            act_left_in    = act_start;
            if (act_start == '0) begin
               row_in       = row_new;
               row_valid_in = 1'b1;
            end
            col_left_in    = col_start;
            busy_in        = 1'b1;
            step_rsp.accepted           = 1'b1;
            step_rsp.same_core_row_miss = row_conflict && same_core;
         end

         // Spend this cycle on write-back, activate or column work
         if (busy_in) begin
            step_rsp.column = act_col_in;
            if (wb_left_in != '0) begin
               wb_left_in     = wb_left_in - 1'b1;
               step_rsp.phase = PH_WRITEBACK;
            end else if (act_left_in != '0) begin
               row_in         = act_row_in;
               row_valid_in   = 1'b1;
               act_left_in    = act_left_in - 1'b1;
               step_rsp.phase = PH_ACTIVATE;
            end else if (col_left_in != '0) begin
               col_left_in    = col_left_in - 1'b1;
               step_rsp.phase = PH_COLUMN;
            end

            // Complete on the last column cycle
            if (col_left_in == '0) begin
               step_rsp.done_res  = 1'b1;
               step_rsp.done_core = act_core_in;
               if (act_is_load_in) begin
                  step_rsp.done_is_load = 1'b1;
                  step_rsp.done_reg     = act_reg_in;
                  mem_op.rd             = 1'b1;
               end else begin
                  mem_op.wr    = 1'b1;
                  mem_op.wdata = act_value_in;
               end
               busy_in = 1'b0;
            end
         end
      end

      step_rsp.open_row = row_in;
   end

   assign mem_index = act_idx_in;

   // Hold configuration and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_delay_ff  <= ROW_DELAY_RESET;
         col_delay_ff  <= COL_DELAY_RESET;
         busy_ff       <= 1'b0;
         row_valid_ff  <= 1'b0;
         row_ff        <= '0;
         wb_left_ff    <= '0;
         act_left_ff   <= '0;
         col_left_ff   <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROW_DELAY: row_delay_ff <= csr_write_data;
               CSR_COL_DELAY: col_delay_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (take) begin
            busy_ff       <= busy_in;
            row_valid_ff  <= row_valid_in;
            row_ff        <= row_in;
            wb_left_ff    <= wb_left_in;
            act_left_ff   <= act_left_in;
            col_left_ff   <= col_left_in;
            prev_valid_ff <= prev_valid_in;
         end
      end
   end

   // Hold the active request payload
   always_ff @(posedge clock) begin
      if (take_req) begin
         act_is_load_ff <= act_is_load_in;
         act_row_ff     <= act_row_in;
         act_col_ff     <= act_col_in;
         act_idx_ff     <= act_idx_in;
         act_value_ff   <= act_value_in;
         act_reg_ff     <= act_reg_in;
         act_core_ff    <= act_core_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/dram_row_buffer_timing.sv =====
// DRAM row buffer timing model: one item per cycle while req_stall is low, the result
// registered in the cycle after its transfer; the single-port word store serves one
// access a cycle. Synchronous reset clears control state, loads row_delay 10 and
// col_delay 2, then runs a clearing pass that zeroes the word store with req_stall high.
// Depends on drbt_pkg, drbt_sched and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dram_row_buffer_timing #(
   parameter int MEM_WORDS = 262144
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [drbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [drbt_pkg::DELAY_W-1:0]      csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_opcode,
   input  wire logic                              req_is_load,
   input  wire logic [drbt_pkg::ADDR_W-1:0]       req_address,
   input  wire logic [drbt_pkg::DATA_W-1:0]       req_store_value,
   input  wire logic [drbt_pkg::REG_W-1:0]        req_dest_reg,
   input  wire logic [drbt_pkg::CORE_W-1:0]       req_core_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_accepted,
   output logic [1:0]                             rsp_phase,
   output logic [drbt_pkg::ROW_W-1:0]             rsp_open_row,
   output logic [drbt_pkg::COL_W-1:0]             rsp_column,
   output logic                                   rsp_done_res,
   output logic                                   rsp_done_is_load,
   output logic [drbt_pkg::DATA_W-1:0]            rsp_load_data,
   output logic [drbt_pkg::REG_W-1:0]             rsp_done_reg,
   output logic [drbt_pkg::CORE_W-1:0]            rsp_done_core,
   output logic                                   rsp_same_core_row_miss
);
   import drbt_pkg::*;

   localparam int IDX_W = $clog2(MEM_WORDS);

   logic               req_take;
   rsp_type            step_rsp;
   mem_op_type         mem_op;
   logic [IDX_W-1:0]   mem_index;

   logic               clearing_ff;
   logic [IDX_W-1:0]   clear_idx_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [DATA_W-1:0]  rd_data_ff;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_addr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [DATA_W-1:0]  mem_ram [MEM_WORDS];

   // Stall while clearing or while a held result waits
   assign req_stall = clearing_ff || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   drbt_sched #(
      .MEM_WORDS (MEM_WORDS)
   ) u_sched (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .take             (req_take),
      .req_opcode       (req_opcode),
      .req_is_load      (req_is_load),
      .req_address      (req_address),
      .req_store_value  (req_store_value),
      .req_dest_reg     (req_dest_reg),
      .req_core_id      (req_core_id),
      .step_rsp         (step_rsp),
      .mem_op           (mem_op),
      .mem_index        (mem_index)
   );

   // Sweep the word store to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_idx_ff == IDX_W'(MEM_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Select the single store port between clearing and requests
   assign mem_we    = clearing_ff || mem_op.wr;
   assign mem_addr  = clearing_ff ? clear_idx_ff : mem_index;
   assign mem_wdata = clearing_ff ? '0 : mem_op.wdata;

   // Word store: one access per cycle, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_addr] <= mem_wdata;
      end
      if (mem_op.rd) begin
         rd_data_ff <= mem_ram[mem_addr];
      end
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted           = rsp_ff.accepted;
   assign rsp_phase              = rsp_ff.phase;
   assign rsp_open_row           = rsp_ff.open_row;
   assign rsp_column             = rsp_ff.column;
   assign rsp_done_res           = rsp_ff.done_res;
   assign rsp_done_is_load       = rsp_ff.done_is_load;
   assign rsp_load_data          = rsp_ff.done_is_load ? rd_data_ff : '0;
   assign rsp_done_reg           = rsp_ff.done_reg;
   assign rsp_done_core          = rsp_ff.done_core;
   assign rsp_same_core_row_miss = rsp_ff.same_core_row_miss;

   `ASSERT_IMPLY(a_no_take_while_clearing, clock, reset, clearing_ff, !req_take)
   `ASSERT_IMPLY(a_one_store_access, clock, reset, mem_op.rd, !mem_we)
   `ASSERT_IMPLY(a_done_on_column, clock, reset, rsp_valid_ff && rsp_ff.done_res, rsp_ff.phase == PH_COLUMN)
   `ASSERT_NEXT(a_read_data_held, clock, reset, rsp_valid_ff && rsp_stall, $stable(rd_data_ff))

endmodule

`default_nettype wire

// ===== tb/tb_dram_row_buffer_timing.sv =====
// Self-checking testbench for dram_row_buffer_timing: directed and random request traffic,
// each result checked field by field against a row buffer predictor that steps with the model.
// Depends on drbt_pkg and the dram_row_buffer_timing RTL.

module tb_dram_row_buffer_timing;
   import drbt_pkg::*;

   localparam int MEM_WORDS   = 262144;
   // Reset runs a clearing pass over the whole word store with no transfer at all
   localparam int STALL_LIMIT = 3 * MEM_WORDS;

   typedef struct packed {
      logic              opcode;
      logic              is_load;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] store_value;
      logic [REG_W-1:0]  dest_reg;
      logic [CORE_W-1:0] core_id;
   } dram_req_t;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        phase;
      logic [ROW_W-1:0]  open_row;
      logic [COL_W-1:0]  column;
      logic              done_res;
      logic              done_is_load;
      logic [DATA_W-1:0] load_data;
      logic [REG_W-1:0]  done_reg;
      logic [CORE_W-1:0] done_core;
      logic              same_core_row_miss;
   } dram_clock_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROW_DELAY;
   logic [DELAY_W-1:0]   csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = 1'b0;
   logic                 req_is_load = 1'b0;
   logic [ADDR_W-1:0]    req_address = '0;
   logic [DATA_W-1:0]    req_store_value = '0;
   logic [REG_W-1:0]     req_dest_reg = '0;
   logic [CORE_W-1:0]    req_core_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_accepted;
   logic [1:0]           rsp_phase;
   logic [ROW_W-1:0]     rsp_open_row;
   logic [COL_W-1:0]     rsp_column;
   logic                 rsp_done_res;
   logic                 rsp_done_is_load;
   logic [DATA_W-1:0]    rsp_load_data;
   logic [REG_W-1:0]     rsp_done_reg;
   logic [CORE_W-1:0]    rsp_done_core;
   logic                 rsp_same_core_row_miss;

   // Gaps on the request side and stalls on the result side
   logic pacing_on = 1'b1;
   int   hold_left = 0;

   dram_clock_t cycle_results_due [$];
   int          req_transfers  = 0;
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;

   // Predictor state: configuration, open row, active access and word store
   logic [DELAY_W-1:0] cfg_row_delay = ROW_DELAY_RESET;
   logic [DELAY_W-1:0] cfg_col_delay = COL_DELAY_RESET;
   logic               mdl_row_valid = 1'b0;
   logic [ROW_W-1:0]   mdl_row = '0;
   logic               mdl_busy = 1'b0;
   logic [DELAY_W-1:0] mdl_wb_left = '0;
   logic [DELAY_W-1:0] mdl_act_left = '0;
   logic [DELAY_W-1:0] mdl_col_left = '0;
   logic               mdl_is_load = 1'b0;
   logic [ADDR_W-1:0]  mdl_addr = '0;
   logic [DATA_W-1:0]  mdl_value = '0;
   logic [REG_W-1:0]   mdl_reg = '0;
   logic [CORE_W-1:0]  mdl_core = '0;
   logic               mdl_prev_valid = 1'b0;
   logic [DATA_W-1:0]  word_mem [int unsigned];

   dram_row_buffer_timing #(.MEM_WORDS(MEM_WORDS)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_opcode             (req_opcode),
      .req_is_load            (req_is_load),
      .req_address            (req_address),
      .req_store_value        (req_store_value),
      .req_dest_reg           (req_dest_reg),
      .req_core_id            (req_core_id),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_accepted           (rsp_accepted),
      .rsp_phase              (rsp_phase),
      .rsp_open_row           (rsp_open_row),
      .rsp_column             (rsp_column),
      .rsp_done_res           (rsp_done_res),
      .rsp_done_is_load       (rsp_done_is_load),
      .rsp_load_data          (rsp_load_data),
      .rsp_done_reg           (rsp_done_reg),
      .rsp_done_core          (rsp_done_core),
      .rsp_same_core_row_miss (rsp_same_core_row_miss)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the row buffer by one DRAM clock and return what that clock shows
   function automatic dram_clock_t predict_dram_clock(input dram_req_t it);
      dram_clock_t      r;
      logic [ROW_W-1:0] row;
      logic             same;
      int unsigned      widx;
      r = '0;
      if (it.opcode && !mdl_busy) begin
         row = it.address[ADDR_W-1:COL_W];
         same = mdl_prev_valid && (mdl_core == it.core_id);
         r.accepted = 1'b1;
         mdl_is_load = it.is_load;
         mdl_addr = it.address;
         mdl_value = it.store_value;
         mdl_reg = it.dest_reg;
         mdl_core = it.core_id;
         mdl_prev_valid = 1'b1;
         mdl_wb_left = '0;
         mdl_act_left = '0;
         if (mdl_row_valid && row != mdl_row) begin
            mdl_wb_left = cfg_row_delay;
            mdl_act_left = cfg_row_delay;
            r.same_core_row_miss = same;
         end else if (!mdl_row_valid) begin
            mdl_act_left = cfg_row_delay;
         end
         // Nothing to activate: the row opens right away
         if (mdl_act_left == 0) begin
            mdl_row = row;
            mdl_row_valid = 1'b1;
         end
         mdl_col_left = (cfg_col_delay == 0) ? DELAY_W'(1) : cfg_col_delay;
         mdl_busy = 1'b1;
      end
      if (mdl_busy) begin
         r.column = mdl_addr[COL_W-1:0];
         if (mdl_wb_left != 0) begin
            mdl_wb_left--;
            r.phase = PH_WRITEBACK;
         end else if (mdl_act_left != 0) begin
            mdl_row = mdl_addr[ADDR_W-1:COL_W];
            mdl_row_valid = 1'b1;
            mdl_act_left--;
            r.phase = PH_ACTIVATE;
         end else if (mdl_col_left != 0) begin
            mdl_col_left--;
            r.phase = PH_COLUMN;
         end
         // Last column cycle performs the access
         if (mdl_col_left == 0) begin
            widx = int'(mdl_addr[ADDR_W-1:2]) % MEM_WORDS;
            r.done_res = 1'b1;
            r.done_core = mdl_core;
            if (mdl_is_load) begin
               r.done_is_load = 1'b1;
               r.load_data = word_mem.exists(widx) ? word_mem[widx] : '0;
               r.done_reg = mdl_reg;
            end else begin
               word_mem[widx] = mdl_value;
            end
            mdl_busy = 1'b0;
         end
      end
      r.open_row = mdl_row;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on each request transfer, check each result transfer, watch for a hang
   always @(posedge clock) begin : transfer_monitor
      dram_req_t   seen;
      dram_clock_t want;
      if (!reset && req_valid && !req_stall) begin
         seen.opcode = req_opcode;
         seen.is_load = req_is_load;
         seen.address = req_address;
         seen.store_value = req_store_value;
         seen.dest_reg = req_dest_reg;
         seen.core_id = req_core_id;
         cycle_results_due.push_back(predict_dram_clock(seen));
         req_transfers++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cycle_results_due.size() == 0) begin
            $error("result transfer with no result expected");
            mismatch_count++;
         end else begin
            want = cycle_results_due.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("phase", want.phase, rsp_phase);
            check_field("open_row", want.open_row, rsp_open_row);
            check_field("column", want.column, rsp_column);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("done_is_load", want.done_is_load, rsp_done_is_load);
            check_field("load_data", want.load_data, rsp_load_data);
            check_field("done_reg", want.done_reg, rsp_done_reg);
            check_field("done_core", want.done_core, rsp_done_core);
            check_field("same_core_row_miss", want.same_core_row_miss,
                        rsp_same_core_row_miss);
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stall the result side: mostly free, short holds, now and then a long one
   always @(negedge clock) begin : rsp_pacing
      int roll;
      roll = $urandom_range(0, 99);
      if (reset || !pacing_on) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (roll < 75) begin
         rsp_stall <= 1'b0;
      end else if (roll < 95) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(10, 40);
      end
   end

   // Present one DRAM clock after an optional gap, return once it transfers
   task automatic drive_clock(input dram_req_t it);
      int gap;
      int seen_count;
      int roll;
      gap = 0;
      roll = $urandom_range(0, 99);
      if (pacing_on) begin
         if (roll >= 93)
            gap = $urandom_range(8, 40);
         else if (roll >= 65)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_is_load <= it.is_load;
      req_address <= it.address;
      req_store_value <= it.store_value;
      req_dest_reg <= it.dest_reg;
      req_core_id <= it.core_id;
      seen_count = req_transfers;
      do @(negedge clock); while (req_transfers == seen_count);
   endtask

   // Plain clock with random payload in the ignored fields
   task automatic idle_clock();
      dram_req_t it;
      it.opcode = 1'b0;
      it.is_load = 1'($urandom);
      it.address = ADDR_W'($urandom);
      it.store_value = $urandom;
      it.dest_reg = REG_W'($urandom);
      it.core_id = CORE_W'($urandom);
      drive_clock(it);
   endtask

   task automatic finish_active_access();
      while (mdl_busy) idle_clock();
   endtask

   // Let the active access complete and every result drain
   task automatic settle();
      finish_active_access();
      req_valid <= 1'b0;
      while (cycle_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_delays(input logic [DELAY_W-1:0] row_d, input logic [DELAY_W-1:0] col_d);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_ROW_DELAY;
      csr_write_data <= row_d;
      @(negedge clock);
      csr_index <= CSR_COL_DELAY;
      csr_write_data <= col_d;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_row_delay = row_d;
      cfg_col_delay = col_d;
   endtask

   function automatic dram_req_t make_req(input logic is_load, input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] value,
                                          input logic [REG_W-1:0] dreg,
                                          input logic [CORE_W-1:0] core);
      dram_req_t it;
      it.opcode = 1'b1;
      it.is_load = is_load;
      it.address = addr;
      it.store_value = value;
      it.dest_reg = dreg;
      it.core_id = core;
      return it;
   endfunction

   task automatic access_and_wait(input dram_req_t it);
      drive_clock(it);
      finish_active_access();
   endtask

   // Reset delays; first access activates only; row miss by the same and another core
   task automatic test_reset_defaults();
      access_and_wait(make_req(1'b0, 20'h00000, 32'h0000_0000, 5'd0, 3'd0));
      access_and_wait(make_req(1'b0, 20'hFFFFC, 32'hFFFF_FFFF, 5'd31, 3'd7));
      access_and_wait(make_req(1'b1, 20'hFFFFF, 32'h0000_0000, 5'd31, 3'd7));
      access_and_wait(make_req(1'b1, 20'h00002, 32'hFFFF_FFFF, 5'd1, 3'd7));
      access_and_wait(make_req(1'b1, 20'h12344, 32'h5A5A_A5A5, 5'd16, 3'd2));
   endtask

   // Request while busy is dropped; the earlier store still lands
   task automatic test_busy_request();
      drive_clock(make_req(1'b0, 20'h12348, 32'hCAFE_0001, 5'd3, 3'd4));
      drive_clock(make_req(1'b0, 20'h12348, 32'hDEAD_0002, 5'd5, 3'd5));
      finish_active_access();
      access_and_wait(make_req(1'b1, 20'h1234B, 32'h0, 5'd9, 3'd4));
   endtask

   // Zero delays: column delay runs as one, rows open at acceptance, back to back
   task automatic test_zero_delays();
      pacing_on <= 1'b0;
      set_delays(10'd0, 10'd0);
      drive_clock(make_req(1'b0, 20'h00C10, 32'h1357_9BDF, 5'd2, 3'd1));
      drive_clock(make_req(1'b1, 20'h00C10, 32'h0, 5'd12, 3'd1));
      drive_clock(make_req(1'b0, 20'h01004, 32'h2468_ACE0, 5'd7, 3'd1));
      drive_clock(make_req(1'b1, 20'h01004, 32'h0, 5'd20, 3'd5));
      drive_clock(make_req(1'b1, 20'h00C13, 32'h0, 5'd30, 3'd5));
      pacing_on <= 1'b1;
   endtask

   // Largest row delay on a row hit, then long delays on a row miss and a row hit
   task automatic test_long_delays();
      set_delays(10'd1023, 10'd1);
      access_and_wait(make_req(1'b1, 20'h00C20, 32'h0, 5'd4, 3'd6));
      set_delays(10'd180, 10'd120);
      access_and_wait(make_req(1'b0, 20'h02200, 32'h8000_0001, 5'd11, 3'd6));
      access_and_wait(make_req(1'b1, 20'h02200, 32'h0, 5'd22, 3'd6));
   endtask

   // Phases of random traffic: mostly requests to a few hot rows, some noise
   task automatic test_random_traffic();
      dram_req_t         it;
      logic [ROW_W-1:0]  hot_rows [3];
      logic [ADDR_W-1:0] stored_addrs [$];
      logic [CORE_W-1:0] last_core;
      int                counted;
      int                pick;
      last_core = '0;
      for (int ph = 0; ph < 6; ph++) begin
         pacing_on <= (ph % 2 == 0);
         if (ph == 0)
            set_delays(10'd1, 10'd1);
         else if (ph == 5)
            set_delays(DELAY_W'($urandom_range(10, 40)), DELAY_W'($urandom_range(1, 8)));
         else
            set_delays(DELAY_W'($urandom_range(0, 6)), DELAY_W'($urandom_range(0, 4)));
         foreach (hot_rows[i]) hot_rows[i] = ROW_W'($urandom);
         counted = 0;
         while (counted < 100) begin
            it.address = {($urandom_range(0, 2) != 0) ? hot_rows[$urandom_range(0, 2)]
                                                        : ROW_W'($urandom),
                          COL_W'($urandom)};
            it.is_load = 1'($urandom);
            // Read back earlier stores half of the time
            if (it.is_load && stored_addrs.size() != 0 && $urandom_range(0, 1) != 0) begin
               pick = $urandom_range(0, stored_addrs.size() - 1);
               it.address = {stored_addrs[pick][ADDR_W-1:2], 2'($urandom)};
            end
            it.store_value = $urandom;
            it.dest_reg = REG_W'($urandom);
            it.core_id = ($urandom_range(0, 1) != 0) ? last_core : CORE_W'($urandom);
            // While busy a request is noise; while free most clocks carry one
            it.opcode = mdl_busy ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 4) != 0);
            if (it.opcode && !mdl_busy) begin
               last_core = it.core_id;
               if (!it.is_load) begin
                  stored_addrs.push_back(it.address);
                  if (stored_addrs.size() > 16) void'(stored_addrs.pop_front());
               end
            end
            if (!(it.opcode && mdl_busy)) counted++;
            drive_clock(it);
         end
      end
      pacing_on <= 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_busy_request();
      test_zero_delays();
      test_long_delays();
      test_random_traffic();
      settle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== dram_row_buffer_timing.f =====
+incdir+rtl/core
rtl/core/drbt_pkg.sv
rtl/core/drbt_sched.sv
rtl/core/dram_row_buffer_timing.sv
tb/tb_dram_row_buffer_timing.sv
